>>> rtl/pidr_pkg.sv
// ----------------------------------------------------------------------------
// PID regulator package
// Types, register indexes and fixed widths shared by the regulator modules.
// ----------------------------------------------------------------------------
package pidr_pkg;

	localparam int DATA_W      = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CNT_W       = 16;
	localparam int FC_W        = 25;
	localparam int DZ_W        = 31;
	localparam int DERIV_SHIFT = 6;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 72;

	localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd16777216;
	localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd16777216;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_GAIN_WINDUP = 3'd3,
		REG_FILTER_COEF = 3'd4,
		REG_DEAD_ZONE   = 3'd5,
		REG_OUT_MAX     = 3'd6,
		REG_OUT_MIN     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic signed [DATA_W-1:0] gain_windup;
		logic [FC_W-1:0]          filter_coef;
		logic [DZ_W-1:0]          dead_zone;
		logic signed [DATA_W-1:0] out_max;
		logic signed [DATA_W-1:0] out_min;
	} cfg_t;

	// sequencer steps of one control request
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DZ,
		ST_MP,
		ST_SUM,
		ST_CLAMP,
		ST_MF,
		ST_FUPD,
		ST_MD,
		ST_DUPD,
		ST_MI,
		ST_IADD,
		ST_MW,
		ST_WADD,
		ST_ICLP,
		ST_OUT
	} state_t;

endpackage

>>> rtl/pidr_mul.sv
// ----------------------------------------------------------------------------
// PID regulator shared multiplier
// Signed 32x32 fixed-point product, arithmetic shift by the fraction width,
// truncated to 32 bits and registered.
// ----------------------------------------------------------------------------
module pidr_mul #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                    clk,
	input  logic signed [pidr_pkg::DATA_W-1:0]      a,
	input  logic signed [pidr_pkg::DATA_W-1:0]      b,
	output logic signed [pidr_pkg::DATA_W-1:0]      p
);

	logic signed [2*pidr_pkg::DATA_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		p <= prod[FRAC_BITS +: pidr_pkg::DATA_W];
	end

endmodule

>>> rtl/pidr_cfg.sv
// ----------------------------------------------------------------------------
// PID regulator configuration registers
// Write-only register file for gains, filter, dead zone and output limits.
// ----------------------------------------------------------------------------
module pidr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pidr_pkg::DATA_W-1:0]         cfg_data,
	output pidr_pkg::cfg_t                      cfg
);

	pidr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= '0;
			cfg_q.gain_i      <= '0;
			cfg_q.gain_d      <= '0;
			cfg_q.gain_windup <= '0;
			cfg_q.filter_coef <= '0;
			cfg_q.dead_zone   <= '0;
			cfg_q.out_max     <= pidr_pkg::OUT_MAX_RST;
			cfg_q.out_min     <= pidr_pkg::OUT_MIN_RST;
		end else if (cfg_we) begin
			case (pidr_pkg::cfg_idx_t'(cfg_addr))
				pidr_pkg::REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				pidr_pkg::REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				pidr_pkg::REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				pidr_pkg::REG_GAIN_WINDUP: cfg_q.gain_windup <= cfg_data;
				pidr_pkg::REG_FILTER_COEF: cfg_q.filter_coef <= cfg_data[pidr_pkg::FC_W-1:0];
				pidr_pkg::REG_DEAD_ZONE:   cfg_q.dead_zone   <= cfg_data[pidr_pkg::DZ_W-1:0];
				pidr_pkg::REG_OUT_MAX:     cfg_q.out_max     <= cfg_data;
				pidr_pkg::REG_OUT_MIN:     cfg_q.out_min     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/pid_regulator_deadzone_antiwindup.sv
// ----------------------------------------------------------------------------
// PID regulator with dead zone and anti-windup
// Fixed-point PID step built around one shared multiplier and a sequencer.
// ----------------------------------------------------------------------------
// A control request (tuser = 0) runs through the steps ST_ERR to ST_OUT
// before the block is ready again; steps that refresh the derivative term
// (every DERIV_DIVIDE steps) add ST_MD and ST_DUPD. The result is loaded
// into the output register in ST_OUT. A restart request (tuser = 1) is
// taken in the idle state and gives no result. The single 32x32 multiplier
// forms the P, filter, D, integral and anti-windup products one after
// another, each followed by the step that uses it. The output register frees
// the input side, so a new request is taken while a result still waits;
// the finishing step of that request holds until the output register is
// free. All arithmetic is Q(FRAC_BITS) two's complement, wrapping at 32 bits.
// Configuration must be written only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module pid_regulator_deadzone_antiwindup #(
	parameter int DERIV_DIVIDE = 1,
	parameter int FRAC_BITS    = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [pidr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [pidr_pkg::DATA_W-1:0]           cfg_data,
	// request stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [31:0] reference, [63:32] feedback, [95:64] sat_error_extra
	input  logic [pidr_pkg::IN_TDATA_W-1:0]       s_tdata,
	// [0] action (0 control step, 1 restart)
	input  logic                                  s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] drive, [63:32] error, [64] saturated, [71:65] zero
	output logic [pidr_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	localparam int W = pidr_pkg::DATA_W;

	pidr_pkg::cfg_t   cfg;
	pidr_pkg::state_t state_q, state_d;

	// request latches
	logic signed [W-1:0] ref_q, fb_q, extra_q;
	// working registers of one step
	logic signed [W-1:0] e_q, edz_q, up_q, sum_q, drive_q, saterr_q, acc_q;
	logic                sat_q;
	// regulator state
	logic signed [W-1:0] integ_q, deriv_q, filt_q, prev_q;
	logic [pidr_pkg::CNT_W-1:0] cnt_q;
	logic                seed_q;
	// output register
	logic                out_valid_q;
	logic [pidr_pkg::OUT_TDATA_W-1:0] out_data_q;

	// shared multiplier
	logic signed [W-1:0] mul_a, mul_b, mul_p;

	logic accept;
	logic out_free;
	logic refresh;
	logic signed [W:0]   dz_t;
	logic signed [W-1:0] dz_res;
	logic signed [W-1:0] diff;

	pidr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	pidr_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign s_tready = (state_q == pidr_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// derivative refresh due on this step
	assign refresh = ({1'b0, cnt_q} + 17'd1) >= 17'(DERIV_DIVIDE);

	// dead zone: pull toward zero, never across it
	always_comb begin
		dz_t   = '0;
		dz_res = e_q;
		if (cfg.dead_zone != '0) begin
			if (e_q > 0) begin
				dz_t   = {e_q[W-1], e_q} - {2'b00, cfg.dead_zone};
				dz_res = dz_t[W] ? '0 : dz_t[W-1:0];
			end else if (e_q < 0) begin
				dz_t   = {e_q[W-1], e_q} + {2'b00, cfg.dead_zone};
				dz_res = (dz_t > 0) ? '0 : dz_t[W-1:0];
			end
		end
	end

	assign diff = filt_q - prev_q;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pidr_pkg::ST_MP: begin
				mul_a = cfg.gain_p;
				mul_b = edz_q;
			end
			pidr_pkg::ST_MF: begin
				mul_a = {{(W-pidr_pkg::FC_W){1'b0}}, cfg.filter_coef};
				mul_b = e_q - filt_q;
			end
			pidr_pkg::ST_MD: begin
				mul_a = cfg.gain_d;
				mul_b = {diff[W-1-pidr_pkg::DERIV_SHIFT:0], {pidr_pkg::DERIV_SHIFT{1'b0}}};
			end
			pidr_pkg::ST_MI: begin
				mul_a = cfg.gain_i;
				mul_b = up_q;
			end
			pidr_pkg::ST_MW: begin
				mul_a = cfg.gain_windup;
				mul_b = saterr_q;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidr_pkg::ST_IDLE:  if (accept && !s_tuser) state_d = pidr_pkg::ST_ERR;
			pidr_pkg::ST_ERR:   state_d = pidr_pkg::ST_DZ;
			pidr_pkg::ST_DZ:    state_d = pidr_pkg::ST_MP;
			pidr_pkg::ST_MP:    state_d = pidr_pkg::ST_SUM;
			pidr_pkg::ST_SUM:   state_d = pidr_pkg::ST_CLAMP;
			pidr_pkg::ST_CLAMP: state_d = pidr_pkg::ST_MF;
			pidr_pkg::ST_MF:    state_d = pidr_pkg::ST_FUPD;
			pidr_pkg::ST_FUPD:  state_d = refresh ? pidr_pkg::ST_MD : pidr_pkg::ST_MI;
			pidr_pkg::ST_MD:    state_d = pidr_pkg::ST_DUPD;
			pidr_pkg::ST_DUPD:  state_d = pidr_pkg::ST_MI;
			pidr_pkg::ST_MI:    state_d = pidr_pkg::ST_IADD;
			pidr_pkg::ST_IADD:  state_d = pidr_pkg::ST_MW;
			pidr_pkg::ST_MW:    state_d = pidr_pkg::ST_WADD;
			pidr_pkg::ST_WADD:  state_d = pidr_pkg::ST_ICLP;
			pidr_pkg::ST_ICLP:  state_d = pidr_pkg::ST_OUT;
			pidr_pkg::ST_OUT:   if (out_free) state_d = pidr_pkg::ST_IDLE;
			default:            state_d = pidr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-step working registers
	always_ff @(posedge clk) begin
		case (state_q)
			pidr_pkg::ST_IDLE: begin
				ref_q   <= s_tdata[W-1:0];
				fb_q    <= s_tdata[2*W-1:W];
				extra_q <= s_tdata[3*W-1:2*W];
			end
			pidr_pkg::ST_ERR:  e_q   <= ref_q - fb_q;
			pidr_pkg::ST_DZ:   edz_q <= dz_res;
			pidr_pkg::ST_SUM: begin
				up_q  <= mul_p;
				sum_q <= mul_p + integ_q + deriv_q;
			end
			pidr_pkg::ST_CLAMP: begin
				// upper limit wins when the limits are inverted
				if (sum_q > cfg.out_max) begin
					drive_q  <= cfg.out_max;
					sat_q    <= 1'b1;
					saterr_q <= cfg.out_max - sum_q + extra_q;
				end else if (sum_q < cfg.out_min) begin
					drive_q  <= cfg.out_min;
					sat_q    <= 1'b1;
					saterr_q <= cfg.out_min - sum_q + extra_q;
				end else begin
					drive_q  <= sum_q;
					sat_q    <= 1'b0;
					saterr_q <= extra_q;
				end
			end
			pidr_pkg::ST_IADD: acc_q <= integ_q + mul_p;
			default: ;
		endcase
	end

	// regulator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			deriv_q     <= '0;
			filt_q      <= '0;
			prev_q      <= '0;
			cnt_q       <= '0;
			seed_q      <= 1'b1;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// drop a taken result unless the finishing step reloads it
			if (out_valid_q && m_tready && state_q != pidr_pkg::ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pidr_pkg::ST_IDLE: begin
					// restart: drop the integrator and arm derivative seeding
					if (accept && s_tuser) begin
						integ_q <= '0;
						seed_q  <= 1'b1;
					end
				end
				pidr_pkg::ST_FUPD: begin
					if (refresh && seed_q) begin
						filt_q <= e_q;
						prev_q <= e_q;
						seed_q <= 1'b0;
					end else if (cfg.filter_coef == '0) begin
						filt_q <= e_q;
					end else begin
						filt_q <= filt_q + mul_p;
					end
					if (!refresh) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				pidr_pkg::ST_DUPD: begin
					deriv_q <= mul_p;
					prev_q  <= filt_q;
					cnt_q   <= '0;
				end
				pidr_pkg::ST_WADD: begin
					integ_q <= (cfg.gain_i != '0) ? (acc_q + mul_p) : '0;
				end
				pidr_pkg::ST_ICLP: begin
					// clamp only when no anti-windup gain is set
					if (cfg.gain_windup == '0) begin
						if (integ_q > cfg.out_max) begin
							integ_q <= cfg.out_max;
						end else if (integ_q < cfg.out_min) begin
							integ_q <= cfg.out_min;
						end
					end
				end
				pidr_pkg::ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {{(pidr_pkg::OUT_TDATA_W-2*W-1){1'b0}},
							sat_q, e_q, drive_q};
					end
				end
				default: ;
			endcase
		end
	end

	// a result appears only from the finishing step of a control request
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == pidr_pkg::ST_OUT)
		else $error("result raised outside the finishing step");

	// a restart clears the integrator and arms seeding at the next edge
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> (integ_q == '0 && seed_q))
		else $error("restart did not clear the integrator");

	// seeding is consumed only by a derivative refresh
	a_seed_use: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(seed_q) |-> $past(state_q) == pidr_pkg::ST_FUPD)
		else $error("seed flag dropped outside the filter update");

	// the decimation count stays below its divide ratio
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} < 17'(DERIV_DIVIDE))
		else $error("derivative divide count out of range");

endmodule
